FILE: rtl/core/fan_demand_with_hysteresis_assert.svh
// Assertion macros for the fan demand block.
// Each macro checks on the rising edge of clk and is held off while rst is high.
`ifndef FAN_DEMAND_WITH_HYSTERESIS_ASSERT_SVH
`define FAN_DEMAND_WITH_HYSTERESIS_ASSERT_SVH

// Same-cycle implication.
`define FDH_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FDH_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fdh_pkg;

  localparam int PWM_BITS_DEF = 8;

  // Fixed field widths
  localparam int TEMP_W     = 19;
  localparam int HYST_W     = 15;
  localparam int WEIGHT_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  // Ratio numerator (temperature delta times weight) and denominator
  // (temperature span times one hundred)
  localparam int N_W = TEMP_W + WEIGHT_W;
  localparam int D_W = TEMP_W + 7;

  // Register reset values
  localparam int PWM_IDLE_RST  = 0;
  localparam int PWM_FULL_RST  = 255;
  localparam int HYST_RST      = 2000;
  localparam int START_RST     = 50000;
  localparam int FULL_RST      = 80000;
  localparam int CRIT_RST      = 95000;
  localparam int WEIGHT_RST    = 100;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PWM_IDLE   = 3'd0;
  localparam cfg_idx_t REG_PWM_FULL   = 3'd1;
  localparam cfg_idx_t REG_HYSTERESIS = 3'd2;
  localparam cfg_idx_t REG_START_TEMP = 3'd3;
  localparam cfg_idx_t REG_FULL_TEMP  = 3'd4;
  localparam cfg_idx_t REG_CRIT_TEMP  = 3'd5;
  localparam cfg_idx_t REG_WEIGHT_PCT = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_RATIO,
    ST_CHECK,
    ST_MUL_SPAN,
    ST_DIV,
    ST_DONE
  } fdh_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/fdh_serial_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier: one multiplier bit per cycle.
module fdh_serial_mul #(
  parameter int AW = fdh_pkg::N_W,
  parameter int BW = fdh_pkg::WEIGHT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int PRW = AW + BW;
  localparam int CW  = $clog2(BW + 1);

  logic           running;
  logic [CW-1:0]  cnt;
  logic [PRW-1:0] a_sh;
  logic [BW-1:0]  b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(BW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= PRW'(a);
      b_sh <= b;
      prod <= '0;
    end else if (running) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fdh_serial_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: one quotient bit per cycle.
// The caller guarantees num < dvs * 2**QW.
module fdh_serial_div #(
  parameter int NW  = fdh_pkg::D_W + 1 + fdh_pkg::PWM_BITS_DEF,
  parameter int DVW = fdh_pkg::D_W + 1,
  parameter int QW  = fdh_pkg::PWM_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  num,
  input  logic [DVW-1:0] dvs,
  output logic           done,
  output logic [QW-1:0]  quot
);

  localparam int CW = $clog2(QW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [NW:0]   diff;

  assign diff = {1'b0, rem} - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(QW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= NW'(dvs) << (QW - 1);
      quot <= '0;
    end else if (running) begin
      // keep the difference only where the shifted divisor fits
      if (!diff[NW]) begin
        rem <= diff[NW-1:0];
      end
      quot <= QW'({quot, ~diff[NW]});
      dsh  <= dsh >> 1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fan_demand_with_hysteresis.sv
`timescale 1ns / 1ps
`default_nettype none

// Fan PWM demand from one temperature sample (millidegrees) per beat, one result beat
// per sample. A critical sample, or one with the ramp off, skips the multiplier and
// divider; otherwise the time to the output register is set by the bit-serial
// shift-add multiplier, used once or twice (temperature delta times weight, then,
// unless that ratio already reaches full demand, ratio numerator times PWM span),
// and by the restoring divider that gives one quotient bit per cycle. One sample is
// worked on at a time; the next is taken as soon as the previous result has moved
// into the output register, even while that result is still stalled. Configuration
// writes are always ready and must only be made while no sample is in flight.
module fan_demand_with_hysteresis #(
  parameter int PWM_BITS = fdh_pkg::PWM_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // sample channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [fdh_pkg::TEMP_W-1:0] temp_sample,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [PWM_BITS-1:0]              pwm_demand,
  output logic                             fan_active,
  output logic                             is_critical,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fdh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fdh_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int TW   = fdh_pkg::TEMP_W;
  localparam int XW   = TW + 1;
  localparam int NRW  = fdh_pkg::N_W;
  localparam int DW   = fdh_pkg::D_W;
  localparam int MBW  = (PWM_BITS > fdh_pkg::WEIGHT_W) ? PWM_BITS : fdh_pkg::WEIGHT_W;
  localparam int MPW  = NRW + MBW;
  localparam int NUMW = DW + 1 + PWM_BITS;
  localparam int DVW  = DW + 1;

  // configuration registers
  logic [PWM_BITS-1:0]            pwm_idle;
  logic [PWM_BITS-1:0]            pwm_full;
  logic [fdh_pkg::HYST_W-1:0]     hysteresis_band;
  logic signed [TW-1:0]           start_temp;
  logic signed [TW-1:0]           full_temp;
  logic signed [TW-1:0]           crit_temp;
  logic [fdh_pkg::WEIGHT_W-1:0]   weight_pct;

  fdh_pkg::fdh_state_t state, state_next;

  logic                 active_flag;
  logic signed [TW-1:0] t_q;
  logic [DW-1:0]        d_q;
  logic [PWM_BITS-1:0]  res_pwm;
  logic                 res_crit;

  // evaluation of the held sample
  logic signed [XW-1:0] t_ext, st_ext, ft_ext, hy_ext;
  logic signed [XW-1:0] start_hi, start_lo, dt_full, den_full;
  logic                 crit, run, active_next, ramp, at_full;
  logic [TW-1:0]        dt_sel, den_sel;
  logic [DW-1:0]        d_next;

  // span of the PWM range
  logic [PWM_BITS-1:0]  span_mag;
  logic                 span_neg;

  // shared multiplier, divider and output register control
  logic                 mul_start, mul_done, div_start, div_done;
  logic [NRW-1:0]       mul_a, n_val;
  logic [MBW-1:0]       mul_b;
  logic [MPW-1:0]       mul_prod;
  logic [NUMW-1:0]      div_num;
  logic [DVW-1:0]       div_dvs;
  logic [PWM_BITS-1:0]  quot;
  logic                 n_ge_d;
  logic                 out_free, out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_idle        <= PWM_BITS'(fdh_pkg::PWM_IDLE_RST);
      pwm_full        <= PWM_BITS'(fdh_pkg::PWM_FULL_RST);
      hysteresis_band <= fdh_pkg::HYST_W'(fdh_pkg::HYST_RST);
      start_temp      <= TW'(fdh_pkg::START_RST);
      full_temp       <= TW'(fdh_pkg::FULL_RST);
      crit_temp       <= TW'(fdh_pkg::CRIT_RST);
      weight_pct      <= fdh_pkg::WEIGHT_W'(fdh_pkg::WEIGHT_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fdh_pkg::REG_PWM_IDLE:   pwm_idle        <= cfg_data[PWM_BITS-1:0];
        fdh_pkg::REG_PWM_FULL:   pwm_full        <= cfg_data[PWM_BITS-1:0];
        fdh_pkg::REG_HYSTERESIS: hysteresis_band <= cfg_data[fdh_pkg::HYST_W-1:0];
        fdh_pkg::REG_START_TEMP: start_temp      <= cfg_data[TW-1:0];
        fdh_pkg::REG_FULL_TEMP:  full_temp       <= cfg_data[TW-1:0];
        fdh_pkg::REG_CRIT_TEMP:  crit_temp       <= cfg_data[TW-1:0];
        fdh_pkg::REG_WEIGHT_PCT: weight_pct      <= cfg_data[fdh_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // hysteresis, ramp and critical decision, and ratio denominator
  always_comb begin
    t_ext    = XW'(t_q);
    st_ext   = XW'(start_temp);
    ft_ext   = XW'(full_temp);
    hy_ext   = signed'(XW'(hysteresis_band));
    start_hi = st_ext + hy_ext;
    start_lo = st_ext - hy_ext;
    dt_full  = t_ext - st_ext;
    den_full = ft_ext - st_ext;
    crit     = (t_q >= crit_temp);
    if (!active_flag) begin
      run         = (t_ext >= start_hi);
      active_next = run;
    end else begin
      run         = !(t_ext <= start_lo);
      active_next = run;
    end
    ramp    = run && (t_q > start_temp);
    at_full = (t_q >= full_temp);
    // at or past the full point the ratio reduces to weight / 100
    dt_sel  = at_full ? TW'(1) : dt_full[TW-1:0];
    den_sel = at_full ? TW'(1) : den_full[TW-1:0];
    // times one hundred: 64 + 32 + 4
    d_next  = DW'({den_sel, 6'b0}) + DW'({den_sel, 5'b0}) + DW'({den_sel, 2'b0});
  end

  always_comb begin
    span_neg = (pwm_idle > pwm_full);
    span_mag = span_neg ? (pwm_idle - pwm_full) : (pwm_full - pwm_idle);
    n_val    = mul_prod[NRW-1:0];
    n_ge_d   = (n_val >= NRW'(d_q));
    // round half away from zero: (2*n*span + d) / (2*d)
    div_num  = NUMW'({mul_prod[NUMW-2:0], 1'b0}) + NUMW'(d_q);
    div_dvs  = {d_q, 1'b0};
    out_free = !out_valid || !out_stall;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fdh_pkg::ST_IDLE:      if (in_valid) state_next = fdh_pkg::ST_EVAL;
      fdh_pkg::ST_EVAL: begin
        if (!crit && ramp) state_next = fdh_pkg::ST_MUL_RATIO;
        else               state_next = fdh_pkg::ST_DONE;
      end
      fdh_pkg::ST_MUL_RATIO: if (mul_done) state_next = fdh_pkg::ST_CHECK;
      fdh_pkg::ST_CHECK: begin
        if (n_ge_d) state_next = fdh_pkg::ST_DONE;
        else        state_next = fdh_pkg::ST_MUL_SPAN;
      end
      fdh_pkg::ST_MUL_SPAN:  if (mul_done) state_next = fdh_pkg::ST_DIV;
      fdh_pkg::ST_DIV:       if (div_done) state_next = fdh_pkg::ST_DONE;
      fdh_pkg::ST_DONE:      if (out_free) state_next = fdh_pkg::ST_IDLE;
      default:               state_next = fdh_pkg::ST_IDLE;
    endcase
  end

  // controls
  always_comb begin
    in_stall  = (state != fdh_pkg::ST_IDLE);
    mul_start = ((state == fdh_pkg::ST_EVAL) && !crit && ramp) ||
                ((state == fdh_pkg::ST_CHECK) && !n_ge_d);
    div_start = (state == fdh_pkg::ST_MUL_SPAN) && mul_done;
    out_load  = (state == fdh_pkg::ST_DONE) && out_free;
    if (state == fdh_pkg::ST_EVAL) begin
      mul_a = NRW'(dt_sel);
      mul_b = MBW'(weight_pct);
    end else begin
      mul_a = n_val;
      mul_b = MBW'(span_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fdh_pkg::ST_IDLE;
      active_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fdh_pkg::ST_EVAL) begin
        active_flag <= crit || active_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      t_q <= temp_sample;
    end
    case (state)
      fdh_pkg::ST_EVAL: begin
        res_crit <= crit;
        res_pwm  <= crit ? pwm_full : pwm_idle;
        d_q      <= d_next;
      end
      fdh_pkg::ST_CHECK: begin
        if (n_ge_d) res_pwm <= pwm_full;
      end
      fdh_pkg::ST_DIV: begin
        if (div_done) res_pwm <= span_neg ? (pwm_idle - quot) : (pwm_idle + quot);
      end
      default: ;
    endcase
    if (out_load) begin
      pwm_demand  <= res_pwm;
      fan_active  <= active_flag;
      is_critical <= res_crit;
    end
  end

  fdh_serial_mul #(
    .AW (NRW),
    .BW (MBW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  fdh_serial_div #(
    .NW  (NUMW),
    .DVW (DVW),
    .QW  (PWM_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .dvs   (div_dvs),
    .done  (div_done),
    .quot  (quot)
  );

`include "fan_demand_with_hysteresis_assert.svh"

  `FDH_CHECK_NOW(a_crit_full, out_valid && is_critical, fan_active && (pwm_demand == pwm_full), "critical beat without full demand and active flag")
  `FDH_CHECK_NOW(a_idle_off, out_valid && !fan_active, (pwm_demand == pwm_idle) && !is_critical, "inactive beat not at idle demand")
  `FDH_CHECK_NOW(a_in_span, out_valid, ((pwm_demand >= pwm_idle) && (pwm_demand <= pwm_full)) || ((pwm_demand <= pwm_idle) && (pwm_demand >= pwm_full)), "demand outside the PWM span")
  `FDH_CHECK_NEXT(a_done_load, (state == fdh_pkg::ST_DONE) && !out_valid, out_valid && (state == fdh_pkg::ST_IDLE), "finished result not loaded into free output register")

endmodule

`default_nettype wire
